[rtl/bdp_pkg.sv]
// ============================================================================
// bdp_pkg: shared types and constants for the delta patch applier
// Payload structs, command and state encodings, header layout constants.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package bdp_pkg;

    localparam int unsigned OLD_DEPTH_DEF   = 65536;
    localparam int unsigned PATCH_DEPTH_DEF = 65536;
    localparam int unsigned HEADER_BYTES    = 32;
    localparam int unsigned TRIPLE_BYTES    = 24;
    localparam int unsigned NLEN_OFFSET     = 24;
    localparam int unsigned CLEN_OFFSET     = 8;
    localparam int unsigned DLEN_OFFSET     = 16;
    localparam logic [63:0] MAGIC_DEF       = 64'h3034_4646_4944_5342;

    // configuration register indexes
    localparam logic [1:0] REG_OLD_SIZE   = 2'd0;
    localparam logic [1:0] REG_PATCH_SIZE = 2'd1;
    localparam logic [1:0] REG_NEW_SIZE   = 2'd2;
    localparam logic [1:0] REG_MAGIC      = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] address;
        logic [7:0]  data;
    } in_t;

    typedef struct packed {
        logic [7:0] new_byte;
        logic [2:0] status;
        logic       last;
    } out_t;

    typedef enum logic [1:0] {
        OP_LOAD_OLD   = 2'd0,
        OP_LOAD_PATCH = 2'd1,
        OP_STEP       = 2'd2,
        OP_NOP        = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] address;
        logic [7:0]  data;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_LOAD     = 3'd0,
        ST_BYTE     = 3'd1,
        ST_FINISHED = 3'd2,
        ST_BADPARAM = 3'd3,
        ST_CORRUPT  = 3'd4,
        ST_MISMATCH = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_CTRL   = 3'd1,
        PH_ADD    = 3'd2,
        PH_COPY   = 3'd3,
        PH_DONE   = 3'd4,
        PH_ERROR  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        W_MAGIC = 3'd0,
        W_NLEN  = 3'd1,
        W_CLEN  = 3'd2,
        W_DLEN  = 3'd3,
        W_M0    = 3'd4,
        W_M1    = 3'd5,
        W_M2    = 3'd6
    } wsel_t;

    typedef enum logic [2:0] {
        S_IDLE     = 3'd0,
        S_LOOP     = 3'd1,
        S_FETCH_RD = 3'd2,
        S_FETCH_WT = 3'd3,
        S_WORD     = 3'd4,
        S_CTRL2    = 3'd5,
        S_BYTE_OUT = 3'd6
    } bstate_t;

    typedef struct packed {
        logic [16:0] old_size;
        logic [16:0] patch_size;
        logic [31:0] new_size;
        logic [63:0] magic_word;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/bdp_front.sv]
// ============================================================================
// bdp_front: input decode and command queue
// Accepts transactions, classifies the opcode and holds up to two commands.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bdp_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire bdp_pkg::in_t  s_payload,
    output logic               cmd_valid,
    output bdp_pkg::cmd_t      cmd,
    input  wire logic          cmd_pop
);
    import bdp_pkg::*;

    cmd_t       q_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic       push;
    cmd_t       dec;

    always_comb begin
        dec.address = s_payload.address;
        dec.data    = s_payload.data;
        case (s_payload.opcode)
            OP_LOAD_OLD:   dec.kind = OP_LOAD_OLD;
            OP_LOAD_PATCH: dec.kind = OP_LOAD_PATCH;
            OP_STEP:       dec.kind = OP_STEP;
            default:       dec.kind = OP_NOP;
        endcase
    end

    assign s_ready   = (count_reg != 2'd2);
    assign push      = s_valid & s_ready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !cmd_pop) count_next = count_reg + 2'd1;
        else if (!push && cmd_pop) count_next = count_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (cmd_pop) rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_reg[wr_ptr_reg] <= dec;
    end

endmodule

`default_nettype wire

[rtl/bdp_back.sv]
// ============================================================================
// bdp_back: patch execution engine
// Holds both memories, walks the header and control triples, emits bytes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bdp_back #(
    parameter int unsigned OLD_DEPTH   = bdp_pkg::OLD_DEPTH_DEF,
    parameter int unsigned PATCH_DEPTH = bdp_pkg::PATCH_DEPTH_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire bdp_pkg::cfg_t cfg,
    input  wire logic          cmd_valid,
    input  wire bdp_pkg::cmd_t cmd,
    output logic               cmd_pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output bdp_pkg::out_t      m_payload
);
    import bdp_pkg::*;

    localparam int OAW = $clog2(OLD_DEPTH);
    localparam int PAW = $clog2(PATCH_DEPTH);

    logic [7:0] old_mem   [OLD_DEPTH];
    logic [7:0] patch_mem [PATCH_DEPTH];
    logic [7:0] ord_reg, prd_reg;

    bstate_t     state_reg, state_next;
    phase_t      phase_reg, phase_next;
    status_t     err_reg, err_next;
    wsel_t       wsel_reg, wsel_next;
    logic [2:0]  k_reg, k_next;
    logic [16:0] fbase_reg, fbase_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] new_pos_reg, new_pos_next;
    logic [63:0] old_pos_reg, old_pos_next;
    logic [31:0] add_rem_reg, add_rem_next;
    logic [31:0] copy_rem_reg, copy_rem_next;
    logic [63:0] seek_reg, seek_next;
    logic [16:0] cp_reg, cp_next;
    logic [16:0] diff_reg, diff_next;
    logic [16:0] extra_reg, extra_next;
    logic        ovf_reg, ovf_next;
    logic        cneg_reg, cneg_next;
    logic        n0_reg, n0_next;
    logic        n1_reg, n1_next;
    logic [62:0] m0_reg, m0_next;
    logic [62:0] m1_reg, m1_next;
    logic        useold_reg, useold_next;
    logic        out_valid_reg, out_valid_next;
    out_t        out_reg, out_next;

    logic [24:0] plim25, olim25;
    logic [16:0] plim, olim;
    logic [31:0] left;
    logic [62:0] wmag;
    logic        wneg;
    logic [16:0] p_rptr;
    logic [24:0] p_rptr25, wa25;
    logic [PAW-1:0] p_raddr;
    logic        old_we, patch_we;
    logic        out_free;

    assign plim25 = (25'(cfg.patch_size) < 25'(PATCH_DEPTH)) ? 25'(cfg.patch_size)
                                                             : 25'(PATCH_DEPTH);
    assign olim25 = (25'(cfg.old_size) < 25'(OLD_DEPTH)) ? 25'(cfg.old_size)
                                                         : 25'(OLD_DEPTH);
    assign plim   = plim25[16:0];
    assign olim   = olim25[16:0];
    assign left   = cfg.new_size - new_pos_reg;
    assign wmag   = acc_reg[62:0];
    assign wneg   = acc_reg[63] & (|wmag);
    assign out_free = ~out_valid_reg | m_ready;

    assign p_rptr25 = 25'(p_rptr);
    assign p_raddr  = p_rptr25[PAW-1:0];
    assign wa25     = 25'(cmd.address);

    always_ff @(posedge aclk) begin
        if (old_we) old_mem[wa25[OAW-1:0]] <= cmd.data;
        ord_reg <= old_mem[old_pos_reg[OAW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (patch_we) patch_mem[wa25[PAW-1:0]] <= cmd.data;
        prd_reg <= patch_mem[p_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_HEADER;
            err_reg       <= ST_LOAD;
            new_pos_reg   <= '0;
            old_pos_reg   <= '0;
            add_rem_reg   <= '0;
            copy_rem_reg  <= '0;
            seek_reg      <= '0;
            cp_reg        <= 17'(HEADER_BYTES);
            diff_reg      <= '0;
            extra_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            err_reg       <= err_next;
            new_pos_reg   <= new_pos_next;
            old_pos_reg   <= old_pos_next;
            add_rem_reg   <= add_rem_next;
            copy_rem_reg  <= copy_rem_next;
            seek_reg      <= seek_next;
            cp_reg        <= cp_next;
            diff_reg      <= diff_next;
            extra_reg     <= extra_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wsel_reg   <= wsel_next;
        k_reg      <= k_next;
        fbase_reg  <= fbase_next;
        acc_reg    <= acc_next;
        cneg_reg   <= cneg_next;
        n0_reg     <= n0_next;
        n1_reg     <= n1_next;
        m0_reg     <= m0_next;
        m1_reg     <= m1_next;
        useold_reg <= useold_next;
        out_reg    <= out_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        err_next       = err_reg;
        wsel_next      = wsel_reg;
        k_next         = k_reg;
        fbase_next     = fbase_reg;
        acc_next       = acc_reg;
        new_pos_next   = new_pos_reg;
        old_pos_next   = old_pos_reg;
        add_rem_next   = add_rem_reg;
        copy_rem_next  = copy_rem_reg;
        seek_next      = seek_reg;
        cp_next        = cp_reg;
        diff_next      = diff_reg;
        extra_next     = extra_reg;
        ovf_next       = ovf_reg;
        cneg_next      = cneg_reg;
        n0_next        = n0_reg;
        n1_next        = n1_reg;
        m0_next        = m0_reg;
        m1_next        = m1_reg;
        useold_next    = useold_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg & ~m_ready;
        cmd_pop        = 1'b0;
        old_we         = 1'b0;
        patch_we       = 1'b0;
        p_rptr         = fbase_reg + 17'(k_reg);

        case (state_reg)
            S_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        OP_STEP: begin
                            if (phase_reg == PH_ERROR) begin
                                out_next       = '{8'd0, err_reg, 1'b0};
                                out_valid_next = 1'b1;
                            end else begin
                                state_next = S_LOOP;
                            end
                        end
                        default: begin
                            old_we   = (cmd.kind == OP_LOAD_OLD) && (wa25 < 25'(OLD_DEPTH));
                            patch_we = (cmd.kind == OP_LOAD_PATCH)
                                       && (wa25 < 25'(PATCH_DEPTH));
                            out_next       = '{8'd0, ST_LOAD, 1'b0};
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            S_LOOP: begin
                case (phase_reg)
                    PH_HEADER: begin
                        if (plim < 17'(HEADER_BYTES)) begin
                            phase_next     = PH_ERROR;
                            err_next       = ST_BADPARAM;
                            out_next       = '{8'd0, ST_BADPARAM, 1'b0};
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end else begin
                            fbase_next = '0;
                            k_next     = '0;
                            wsel_next  = W_MAGIC;
                            state_next = S_FETCH_RD;
                        end
                    end
                    PH_CTRL: begin
                        if (new_pos_reg >= cfg.new_size) begin
                            phase_next = PH_DONE;
                        end else if (cp_reg > plim || (plim - cp_reg) < 17'(TRIPLE_BYTES)) begin
                            phase_next     = PH_ERROR;
                            err_next       = ST_CORRUPT;
                            out_next       = '{8'd0, ST_CORRUPT, 1'b0};
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end else begin
                            fbase_next = cp_reg;
                            k_next     = '0;
                            wsel_next  = W_M0;
                            state_next = S_FETCH_RD;
                        end
                    end
                    PH_ADD: begin
                        if (add_rem_reg != '0) begin
                            p_rptr = diff_reg;
                            if (diff_reg >= plim) begin
                                phase_next     = PH_ERROR;
                                err_next       = ST_CORRUPT;
                                out_next       = '{8'd0, ST_CORRUPT, 1'b0};
                                out_valid_next = 1'b1;
                                state_next     = S_IDLE;
                            end else begin
                                useold_next  = old_pos_reg < 64'(olim);
                                diff_next    = diff_reg + 17'd1;
                                old_pos_next = old_pos_reg + 64'd1;
                                new_pos_next = new_pos_reg + 32'd1;
                                add_rem_next = add_rem_reg - 32'd1;
                                state_next   = S_BYTE_OUT;
                            end
                        end else if (ovf_reg) begin
                            phase_next     = PH_ERROR;
                            err_next       = ST_CORRUPT;
                            out_next       = '{8'd0, ST_CORRUPT, 1'b0};
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end else begin
                            phase_next = PH_COPY;
                        end
                    end
                    PH_COPY: begin
                        if (copy_rem_reg != '0) begin
                            p_rptr = extra_reg;
                            if (extra_reg >= plim) begin
                                phase_next     = PH_ERROR;
                                err_next       = ST_CORRUPT;
                                out_next       = '{8'd0, ST_CORRUPT, 1'b0};
                                out_valid_next = 1'b1;
                                state_next     = S_IDLE;
                            end else begin
                                useold_next   = 1'b0;
                                extra_next    = extra_reg + 17'd1;
                                new_pos_next  = new_pos_reg + 32'd1;
                                copy_rem_next = copy_rem_reg - 32'd1;
                                state_next    = S_BYTE_OUT;
                            end
                        end else begin
                            old_pos_next = old_pos_reg + seek_reg;
                            phase_next   = PH_CTRL;
                        end
                    end
                    PH_DONE: begin
                        out_next       = '{8'd0, ST_FINISHED, 1'b0};
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    default: begin
                        out_next       = '{8'd0, err_reg, 1'b0};
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                endcase
            end

            S_FETCH_RD: begin
                state_next = S_FETCH_WT;
            end

            // little endian: each byte enters at the top
            S_FETCH_WT: begin
                acc_next = {prd_reg, acc_reg[63:8]};
                k_next   = k_reg + 3'd1;
                state_next = (k_reg == 3'd7) ? S_WORD : S_FETCH_RD;
            end

            S_WORD: begin
                state_next = S_FETCH_RD;
                k_next     = '0;
                case (wsel_reg)
                    W_MAGIC: begin
                        if (acc_reg != cfg.magic_word) begin
                            phase_next     = PH_ERROR;
                            err_next       = ST_CORRUPT;
                            out_next       = '{8'd0, ST_CORRUPT, 1'b0};
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end else begin
                            fbase_next = 17'(NLEN_OFFSET);
                            wsel_next  = W_NLEN;
                        end
                    end
                    W_NLEN: begin
                        if (wneg) begin
                            phase_next     = PH_ERROR;
                            err_next       = ST_CORRUPT;
                            out_next       = '{8'd0, ST_CORRUPT, 1'b0};
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end else if (wmag != 63'(cfg.new_size)) begin
                            phase_next     = PH_ERROR;
                            err_next       = ST_MISMATCH;
                            out_next       = '{8'd0, ST_MISMATCH, 1'b0};
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end else begin
                            fbase_next = 17'(CLEN_OFFSET);
                            wsel_next  = W_CLEN;
                        end
                    end
                    W_CLEN: begin
                        cneg_next = wneg;
                        diff_next = (wmag > 63'(plim - 17'(HEADER_BYTES))) ? plim
                                    : 17'(HEADER_BYTES) + wmag[16:0];
                        fbase_next = 17'(DLEN_OFFSET);
                        wsel_next  = W_DLEN;
                    end
                    W_DLEN: begin
                        if (cneg_reg || wneg) begin
                            phase_next     = PH_ERROR;
                            err_next       = ST_CORRUPT;
                            out_next       = '{8'd0, ST_CORRUPT, 1'b0};
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end else begin
                            extra_next = (wmag > 63'(plim - diff_reg)) ? plim
                                         : diff_reg + wmag[16:0];
                            cp_next      = 17'(HEADER_BYTES);
                            new_pos_next = '0;
                            old_pos_next = '0;
                            phase_next   = PH_CTRL;
                            state_next   = S_LOOP;
                        end
                    end
                    W_M0: begin
                        m0_next    = wmag;
                        n0_next    = wneg;
                        fbase_next = cp_reg + 17'd8;
                        wsel_next  = W_M1;
                    end
                    W_M1: begin
                        m1_next    = wmag;
                        n1_next    = wneg;
                        fbase_next = cp_reg + 17'd16;
                        wsel_next  = W_M2;
                    end
                    default: begin
                        cp_next   = cp_reg + 17'(TRIPLE_BYTES);
                        seek_next = wneg ? (64'd0 - {1'b0, wmag}) : {1'b0, wmag};
                        if (n0_reg || n1_reg || (m0_reg > 63'(left))) begin
                            phase_next     = PH_ERROR;
                            err_next       = ST_CORRUPT;
                            out_next       = '{8'd0, ST_CORRUPT, 1'b0};
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end else begin
                            add_rem_next = m0_reg[31:0];
                            state_next   = S_CTRL2;
                        end
                    end
                endcase
            end

            S_CTRL2: begin
                ovf_next      = m1_reg > 63'(left - add_rem_reg);
                copy_rem_next = (m1_reg > 63'(left - add_rem_reg)) ? 32'd0 : m1_reg[31:0];
                phase_next    = PH_ADD;
                state_next    = S_LOOP;
            end

            S_BYTE_OUT: begin
                out_next.new_byte = prd_reg + (useold_reg ? ord_reg : 8'd0);
                out_next.status   = ST_BYTE;
                out_next.last     = (new_pos_reg == cfg.new_size);
                out_valid_next    = 1'b1;
                state_next        = S_IDLE;
            end

            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

[rtl/binary_delta_patch_apply.sv]
// ============================================================================
// binary_delta_patch_apply: uncompressed delta patch applier
// Loads old file and patch into memories, then emits new-file bytes on request.
// ============================================================================
// Usage: write old_size, patch_size, new_size and magic_word on the cfg_*
// channel (always ready) while the block is idle. Send opcode 0/1 transactions
// on s_* to load old/patch bytes, then opcode 2 transactions, one per new-file
// byte; every input transaction yields exactly one m_* result.
// Result path: a load is answered straight from the idle state; a step that yields
// a data byte passes the queue pop, one patch memory read with the old memory
// read beside it, then the output register; a phase change inside a triple
// adds a further S_LOOP pass. The first step reads the 32-byte header through
// the single patch read port, each byte taking an S_FETCH_RD and S_FETCH_WT
// state; each control triple costs 24 byte reads. One command is executed at a
// time; a two-entry queue keeps accepting transactions meanwhile.
// Reset: state, position and cfg registers take their defaults, the patch run
// restarts at the header; memories keep their contents, undefined until loaded.
// A stalled receiver holds the result register; the queue then fills and
// s_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module binary_delta_patch_apply #(
    parameter int unsigned OLD_DEPTH   = bdp_pkg::OLD_DEPTH_DEF,
    parameter int unsigned PATCH_DEPTH = bdp_pkg::PATCH_DEPTH_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire bdp_pkg::in_t  s_payload,
    output logic               m_valid,
    input  wire logic          m_ready,
    output bdp_pkg::out_t      m_payload,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [63:0]   cfg_data
);
    import bdp_pkg::*;

    cfg_t cfg_reg;
    logic cmd_valid, cmd_pop;
    cmd_t cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.old_size   <= '0;
            cfg_reg.patch_size <= '0;
            cfg_reg.new_size   <= '0;
            cfg_reg.magic_word <= MAGIC_DEF;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_OLD_SIZE:   cfg_reg.old_size   <= cfg_data[16:0];
                REG_PATCH_SIZE: cfg_reg.patch_size <= cfg_data[16:0];
                REG_NEW_SIZE:   cfg_reg.new_size   <= cfg_data[31:0];
                REG_MAGIC:      cfg_reg.magic_word <= cfg_data;
                default: ;
            endcase
        end
    end

    bdp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    bdp_back #(
        .OLD_DEPTH   (OLD_DEPTH),
        .PATCH_DEPTH (PATCH_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

`default_nettype wire

[verif/bdp_checker.sv]
// ============================================================================
// bdp_result_checker: result predictor and scoreboard for the patch applier
// Watches the config, input and result channels, keeps its own copy of both
// memories and the patch-run state, and compares each result field by field.
// ============================================================================
`timescale 1ns / 1ps

module bdp_result_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  bdp_pkg::in_t  s_payload,
    input  logic          m_valid,
    input  logic          m_ready,
    input  bdp_pkg::out_t m_payload,
    input  logic          cfg_valid,
    input  logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [63:0]   cfg_data,
    output int            fail_count,
    output int            pending,
    output int            byte_count
);
    import bdp_pkg::*;

    logic [7:0]  old_mem   [0:OLD_DEPTH_DEF-1];
    logic [7:0]  patch_mem [0:PATCH_DEPTH_DEF-1];

    logic [16:0] old_size_q;
    logic [16:0] patch_size_q;
    logic [31:0] new_size_q;
    logic [63:0] magic_q;

    phase_t      run_phase;
    status_t     sticky_err;
    logic [31:0] new_pos;
    logic [63:0] old_pos;
    logic [31:0] add_left;
    logic [31:0] copy_left;
    logic [63:0] seek_amt;
    logic [31:0] ctrl_ptr;
    logic [31:0] diff_ptr;
    logic [31:0] extra_ptr;
    bit          copy_over;

    out_t expected_results[$];

    initial begin
        fail_count = 0;
        pending    = 0;
        byte_count = 0;
    end

    // sign-magnitude little-endian 64-bit field at a patch offset
    function automatic logic [63:0] sm_field(int unsigned pos, output bit neg);
        logic [63:0] mag;
        mag = {1'b0, patch_mem[pos+7][6:0], patch_mem[pos+6], patch_mem[pos+5],
               patch_mem[pos+4], patch_mem[pos+3], patch_mem[pos+2],
               patch_mem[pos+1], patch_mem[pos]};
        neg = patch_mem[pos+7][7] && (mag != 0);
        return mag;
    endfunction

    function automatic out_t fail_with(status_t code);
        out_t r;
        r          = '0;
        r.status   = code;
        run_phase  = PH_ERROR;
        sticky_err = code;
        return r;
    endfunction

    function automatic out_t predict_result(in_t it);
        out_t        r;
        int unsigned plim;
        int unsigned olim;
        logic [63:0] m0, m1, m2, left, magic, nlen, clen, dlen;
        bit          n0, n1, n2, nn, cn, dn;
        logic [8:0]  b;
        r = '0;
        case (kind_t'(it.opcode))
            OP_LOAD_OLD: begin
                old_mem[it.address] = it.data;
                return r;
            end
            OP_LOAD_PATCH: begin
                patch_mem[it.address] = it.data;
                return r;
            end
            OP_NOP: return r;
            default: ;
        endcase
        if (run_phase == PH_ERROR) begin
            r.status = sticky_err;
            return r;
        end
        plim = (patch_size_q < PATCH_DEPTH_DEF) ? patch_size_q : PATCH_DEPTH_DEF;
        if (run_phase == PH_HEADER) begin
            if (plim < HEADER_BYTES) return fail_with(ST_BADPARAM);
            magic = '0;
            for (int k = 7; k >= 0; k--) magic = {magic[55:0], patch_mem[k]};
            if (magic != magic_q) return fail_with(ST_CORRUPT);
            nlen = sm_field(NLEN_OFFSET, nn);
            if (nn) return fail_with(ST_CORRUPT);
            if (nlen != {32'b0, new_size_q}) return fail_with(ST_MISMATCH);
            clen = sm_field(CLEN_OFFSET, cn);
            dlen = sm_field(DLEN_OFFSET, dn);
            if (cn || dn) return fail_with(ST_CORRUPT);
            ctrl_ptr  = HEADER_BYTES;
            diff_ptr  = (clen > plim - HEADER_BYTES) ? plim : HEADER_BYTES + clen[31:0];
            extra_ptr = (dlen > plim - diff_ptr) ? plim : diff_ptr + dlen[31:0];
            new_pos   = '0;
            old_pos   = '0;
            run_phase = PH_CTRL;
        end
        // zero-length triples are consumed here until something happens
        while (1'b1) begin
            case (run_phase)
                PH_DONE: begin
                    r.status = ST_FINISHED;
                    return r;
                end
                PH_CTRL: begin
                    if (new_pos >= new_size_q) begin
                        run_phase = PH_DONE;
                    end else begin
                        if (ctrl_ptr > plim || plim - ctrl_ptr < TRIPLE_BYTES)
                            return fail_with(ST_CORRUPT);
                        m0 = sm_field(ctrl_ptr, n0);
                        m1 = sm_field(ctrl_ptr + 8, n1);
                        m2 = sm_field(ctrl_ptr + 16, n2);
                        ctrl_ptr += TRIPLE_BYTES;
                        if (n0 || n1) return fail_with(ST_CORRUPT);
                        left = {32'b0, new_size_q} - {32'b0, new_pos};
                        if (m0 > left) return fail_with(ST_CORRUPT);
                        add_left  = m0[31:0];
                        copy_over = m1 > left - m0;
                        copy_left = copy_over ? '0 : m1[31:0];
                        seek_amt  = n2 ? -m2 : m2;
                        run_phase = PH_ADD;
                    end
                end
                PH_ADD: begin
                    if (add_left != 0) begin
                        if (diff_ptr >= plim) return fail_with(ST_CORRUPT);
                        olim = (old_size_q < OLD_DEPTH_DEF) ? old_size_q : OLD_DEPTH_DEF;
                        b = patch_mem[diff_ptr];
                        if (old_pos < olim) b = b + old_mem[old_pos[15:0]];
                        diff_ptr++;
                        old_pos++;
                        new_pos++;
                        add_left--;
                        r.new_byte = b[7:0];
                        r.status   = ST_BYTE;
                        r.last     = (new_pos == new_size_q);
                        return r;
                    end
                    if (copy_over) return fail_with(ST_CORRUPT);
                    run_phase = PH_COPY;
                end
                default: begin
                    if (copy_left != 0) begin
                        if (extra_ptr >= plim) return fail_with(ST_CORRUPT);
                        r.new_byte = patch_mem[extra_ptr];
                        extra_ptr++;
                        new_pos++;
                        copy_left--;
                        r.status = ST_BYTE;
                        r.last   = (new_pos == new_size_q);
                        return r;
                    end
                    old_pos   = old_pos + seek_amt;
                    run_phase = PH_CTRL;
                end
            endcase
        end
        return r;
    endfunction

    task automatic report_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t mismatch on %s: expected %0h actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        out_t want;
        if (!aresetn) begin
            old_size_q   = '0;
            patch_size_q = '0;
            new_size_q   = '0;
            magic_q      = MAGIC_DEF;
            run_phase    = PH_HEADER;
            sticky_err   = ST_LOAD;
            new_pos      = '0;
            old_pos      = '0;
            add_left     = '0;
            copy_left    = '0;
            seek_amt     = '0;
            ctrl_ptr     = HEADER_BYTES;
            diff_ptr     = '0;
            extra_ptr    = '0;
            copy_over    = 1'b0;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_OLD_SIZE:   old_size_q   = cfg_data[16:0];
                    REG_PATCH_SIZE: patch_size_q = cfg_data[16:0];
                    REG_NEW_SIZE:   new_size_q   = cfg_data[31:0];
                    REG_MAGIC:      magic_q      = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_results.push_back(predict_result(s_payload));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected result transaction: actual %0h",
                             $time, m_payload);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    report_field("new_byte", want.new_byte, m_payload.new_byte);
                    report_field("status", 8'(want.status), 8'(m_payload.status));
                    report_field("last", 8'(want.last), 8'(m_payload.last));
                    if (want.status == ST_BYTE) byte_count++;
                end
            end
        end
        pending <= expected_results.size();
    end

endmodule

[verif/tb_top.sv]
// ============================================================================
// tb_top: stimulus and verdict for the delta patch applier
// Loads an old image and a generated well-formed patch with random content,
// interleaves noise, then steps out the whole new file under varied idling,
// register changes and a long result-side hold-off.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;
    import bdp_pkg::*;

    localparam int unsigned OLD_LOADED = 448;
    localparam int unsigned NEW_LEN    = 250;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_t         s_payload;
    logic        m_valid;
    logic        m_ready;
    out_t        m_payload;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    int fail_count;
    int pending;
    int byte_count;
    int idle_pct;
    int stall_pct;
    int hold_left;
    int sent_count;
    int mode_idx;
    bit hold_req;

    logic [7:0] patch_img[$];

    binary_delta_patch_apply DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    bdp_result_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .byte_count(byte_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        m_ready   = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req  <= 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic next_mode();
        mode_idx++;
        case (mode_idx % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 70; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 70; end
            default: begin idle_pct = 23; stall_pct = 23; end
        endcase
    endtask

    task automatic put_item(logic [1:0] op, logic [15:0] addr, logic [7:0] dat);
        in_t it;
        it.opcode  = op;
        it.address = addr;
        it.data    = dat;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
        if (sent_count % 250 == 0) next_mode();
    endtask

    // loads and no-ops that leave the patch image itself untouched
    task automatic put_noise();
        case ($urandom_range(2))
            0: put_item(OP_NOP, 16'($urandom), 8'($urandom));
            1: put_item(OP_LOAD_OLD, 16'($urandom), 8'($urandom));
            default: put_item(OP_LOAD_PATCH,
                              16'($urandom_range(65535, patch_img.size())), 8'($urandom));
        endcase
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic push_sm(logic [63:0] mag, bit neg);
        logic [7:0] b;
        for (int i = 0; i < 8; i++) begin
            b = mag[8*i +: 8];
            if (i == 7 && neg) b[7] = 1'b1;
            patch_img.push_back(b);
        end
    endtask

    initial begin : stimulus
        int          add_q[$];
        int          copy_q[$];
        longint      seek_q[$];
        bit          negz_q[$];
        int          rem, a, c, p, target, diff_total, extra_total, steps;
        longint      s;
        int unsigned old_sizes[4];

        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_payload  = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        hold_req   = 1'b0;
        idle_pct   = 0;
        stall_pct  = 0;
        mode_idx   = 0;
        sent_count = 0;
        old_sizes  = '{0, 300, 65536, OLD_LOADED};

        // control triples: old position kept in [-32, 416] so reads stay loaded
        rem = NEW_LEN; p = 0; diff_total = 0; extra_total = 0;
        while (rem > 0) begin
            if ($urandom_range(7) == 0) begin
                a = 0; c = 0;
            end else begin
                a = $urandom_range((rem < 16) ? rem : 16);
                c = $urandom_range((rem - a < 16) ? rem - a : 16);
            end
            target = int'($urandom_range(432)) - 32;
            s = target - (p + a);
            p = target;
            add_q.push_back(a);
            copy_q.push_back(c);
            seek_q.push_back(s);
            negz_q.push_back(s == 0 && $urandom_range(1));
            rem -= a + c;
            diff_total += a;
            extra_total += c;
        end
        for (int k = 0; k < 8; k++) patch_img.push_back(MAGIC_DEF[8*k +: 8]);
        push_sm(64'(TRIPLE_BYTES * add_q.size()), 1'b0);
        push_sm(64'(diff_total), 1'b0);
        push_sm(64'(NEW_LEN), 1'b0);
        foreach (add_q[k]) begin
            push_sm(64'(add_q[k]), 1'b0);
            push_sm(64'(copy_q[k]), 1'b0);
            push_sm((seek_q[k] < 0) ? -seek_q[k] : seek_q[k], seek_q[k] < 0 || negz_q[k]);
        end
        repeat (diff_total + extra_total) patch_img.push_back(8'($urandom));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes on loads and the unused opcode
        put_item(OP_NOP, 16'hFFFF, 8'hFF);
        put_item(OP_NOP, 16'h0000, 8'h00);
        put_item(OP_LOAD_OLD, 16'hFFFF, 8'h00);
        put_item(OP_LOAD_OLD, 16'hFFFF, 8'hFF);
        put_item(OP_LOAD_PATCH, 16'hFFFF, 8'hFF);
        put_item(OP_LOAD_PATCH, 16'hFFFF, 8'h00);

        for (int k = 0; k < OLD_LOADED; k++) begin
            if ($urandom_range(9) == 0) put_noise();
            put_item(OP_LOAD_OLD, 16'(k), 8'($urandom));
        end
        foreach (patch_img[k]) begin
            if ($urandom_range(9) == 0) put_noise();
            put_item(OP_LOAD_PATCH, 16'(k), patch_img[k]);
        end

        wait_idle();
        write_reg(REG_OLD_SIZE, 64'(OLD_LOADED));
        write_reg(REG_PATCH_SIZE, 64'(patch_img.size()));
        write_reg(REG_NEW_SIZE, 64'(NEW_LEN));
        write_reg(REG_MAGIC, MAGIC_DEF);

        // one byte per step, then a few steps past the end
        for (steps = 0; steps < NEW_LEN + 4; steps++) begin
            if (steps > 0 && steps % 100 == 0) begin
                wait_idle();
                write_reg(REG_OLD_SIZE, 64'(old_sizes[(steps / 100) % 4]));
                next_mode();
            end
            if (steps == 220) hold_req <= 1'b1;
            if ($urandom_range(6) == 0) put_noise();
            put_item(OP_STEP, 16'($urandom), 8'($urandom));
        end

        // once finished, register extremes must not disturb the result
        wait_idle();
        write_reg(REG_NEW_SIZE, 64'hFFFF_FFFF);
        write_reg(REG_NEW_SIZE, 64'h0);
        write_reg(REG_OLD_SIZE, 64'h0);
        write_reg(REG_PATCH_SIZE, 64'd65536);
        write_reg(REG_PATCH_SIZE, 64'h0);
        write_reg(REG_MAGIC, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_MAGIC, 64'h0);
        repeat (3) put_item(OP_STEP, 16'($urandom), 8'($urandom));

        wait_idle();
        repeat (100) @(posedge aclk);
        $display("covered %0d input transactions, %0d new-file bytes from a %0d-byte patch",
                 sent_count, byte_count, patch_img.size());
        $display("with %0d control triples, idling phases, register changes, long hold-off",
                 add_q.size());
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
